// ----- design/rrfq_pkg.sv -----
// Shared types and constants for the round robin flow queue.
`timescale 1ns / 1ps
`default_nettype none
package rrfq_pkg;
   localparam int NumFlows    = 16;
   localparam int FifoDepth   = 16;
   localparam int HandleWidth = 16;
   localparam int FlowW  = $clog2(NumFlows);
   localparam int SlotW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
   localparam int CountW = $clog2(FifoDepth + 1);
   localparam int StoreW = FlowW + SlotW;
   localparam int StoreDepth = NumFlows * (1 << SlotW);

   typedef enum logic [1:0] {
      ACT_ENQ   = 2'd0,
      ACT_DEQ   = 2'd1,
      ACT_ERASE = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_INACTIVE = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;
endpackage
`default_nettype wire

// ----- design/rrfq_ram.sv -----
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module rrfq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data_ff
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- design/rrfq_ctrl.sv -----
// Controller: capture cycle then execute cycle per request.
`timescale 1ns / 1ps
`default_nettype none
module rrfq_ctrl import rrfq_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   output dp_cmd_type cmd
);
   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_EXEC;
         S_EXEC: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy        = (state_ff == S_EXEC);
   assign cmd.capture = (state_ff == S_IDLE) && start;
   assign cmd.execute = (state_ff == S_EXEC);
endmodule
`default_nettype wire

// ----- design/rrfq_dp.sv -----
// Datapath: flow links, FIFO pointers, task store and result registers.
`timescale 1ns / 1ps
`default_nettype none
module rrfq_dp import rrfq_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dp_cmd_type             cmd,
   input  wire logic [1:0]             req_action,
   input  wire logic [3:0]             req_flow_id,
   input  wire logic [15:0]            req_task_handle,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [15:0]                 rsp_out_handle,
   output logic [3:0]                  rsp_out_flow,
   output logic                        rsp_all_empty
);
   logic [NumFlows-1:0] active_ff, active_in;
   logic [FlowW-1:0]    next_ff [NumFlows];
   logic [FlowW-1:0]    prev_ff [NumFlows];
   logic [SlotW-1:0]    head_ff [NumFlows];
   logic [CountW-1:0]   count_ff [NumFlows];
   logic [FlowW-1:0]    cur_ff, cur_in;

   action_type          act_ff;
   logic [3:0]          fid_ff;
   logic [HandleWidth-1:0] hdl_ff;

   logic                rv_ff;
   status_type          rs_ff;
   logic [15:0]         rh_ff;
   logic [3:0]          rf_ff;
   logic                re_ff;
   logic                deq_ok_ff, deq_ok_in;

   // task store: read address is the current flow head, sampled in the execute cycle
   logic                ram_we;
   logic [StoreW-1:0]   ram_wa, ram_ra;
   logic [HandleWidth-1:0] ram_rd;

   rrfq_ram #(.Width(HandleWidth), .Depth(StoreDepth)) u_store (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(hdl_ff),
      .rd_addr(ram_ra), .rd_data_ff(ram_rd)
   );
   assign ram_ra = {cur_ff, head_ff[cur_ff]};

   logic            in_range;
   logic [FlowW-1:0] f;
   logic            f_act;
   logic            none_act;
   logic            do_enq, do_link, do_deq, do_unlink, do_clear;
   logic [FlowW-1:0] uf, un, up, lp;
   status_type      st;
   logic [SlotW-1:0] slot;

   always_comb begin
      in_range = ({28'd0, fid_ff} < 32'(NumFlows));
      f        = fid_ff[FlowW-1:0];
      f_act    = in_range && active_ff[f];
      none_act = (active_ff == '0);
      do_enq = 1'b0; do_link = 1'b0; do_deq = 1'b0;
      do_unlink = 1'b0; do_clear = 1'b0;
      st = ST_OK;
      uf = f;
      case (act_ff)
         ACT_ENQ: begin
            if (!in_range) st = ST_INACTIVE;
            else if (f_act && count_ff[f] >= CountW'(FifoDepth)) st = ST_FULL;
            else begin
               do_enq  = 1'b1;
               do_link = !f_act;
            end
         end
         ACT_DEQ: begin
            if (!active_ff[cur_ff]) st = ST_EMPTY;
            else begin
               do_deq    = 1'b1;
               uf        = cur_ff;
               do_unlink = (count_ff[cur_ff] == CountW'(1));
            end
         end
         ACT_ERASE: begin
            if (!f_act) st = ST_INACTIVE;
            else do_unlink = 1'b1;
         end
         default: do_clear = 1'b1;
      endcase
      un   = next_ff[uf];
      up   = prev_ff[uf];
      lp   = prev_ff[cur_ff];
      slot = SlotW'((CountW + SlotW + 1)'(head_ff[f]) + (CountW + SlotW + 1)'(count_ff[f]));
      if (FifoDepth != (1 << SlotW))
         slot = SlotW'(((CountW + SlotW + 1)'(head_ff[f])
                + (CountW + SlotW + 1)'(count_ff[f])) % FifoDepth);
      if (do_link) slot = '0;
      ram_we = cmd.execute && do_enq;
      ram_wa = {f, slot};

      active_in = active_ff;
      cur_in    = cur_ff;
      deq_ok_in = do_deq;
      if (do_link) begin
         active_in[f] = 1'b1;
         cur_in       = f;
      end
      if (do_deq && !do_unlink) cur_in = next_ff[cur_ff];
      if (do_unlink) begin
         active_in[uf] = 1'b0;
         if (cur_ff == uf && un != uf) cur_in = un;
      end
      if (do_clear) begin
         active_in = '0;
         cur_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= action_type'(req_action);
         fid_ff <= req_flow_id;
         hdl_ff <= req_task_handle[HandleWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         cur_ff    <= '0;
         rv_ff     <= 1'b0;
         deq_ok_ff <= 1'b0;
         for (int i = 0; i < NumFlows; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         rv_ff <= cmd.execute;
         if (cmd.execute) begin
            active_ff <= active_in;
            cur_ff    <= cur_in;
            deq_ok_ff <= deq_ok_in;
            rs_ff     <= st;
            rf_ff     <= do_deq ? 4'(uf) : 4'd0;
            re_ff     <= (active_in == '0);
            if (do_enq) begin
               if (do_link) begin
                  head_ff[f]  <= '0;
                  count_ff[f] <= CountW'(1);
                  if (none_act) begin
                     next_ff[f] <= f;
                     prev_ff[f] <= f;
                  end else begin
                     next_ff[f]      <= cur_ff;
                     prev_ff[f]      <= lp;
                     next_ff[lp]     <= f;
                     prev_ff[cur_ff] <= f;
                  end
               end else count_ff[f] <= count_ff[f] + CountW'(1);
            end
            if (do_deq) begin
               head_ff[uf] <= (FifoDepth == (1 << SlotW)) ? head_ff[uf] + SlotW'(1)
                  : ((head_ff[uf] == SlotW'(FifoDepth - 1)) ? '0 : head_ff[uf] + SlotW'(1));
               count_ff[uf] <= count_ff[uf] - CountW'(1);
            end
            if (do_unlink) begin
               prev_ff[un] <= up;
               next_ff[up] <= un;
               head_ff[uf]  <= '0;
               count_ff[uf] <= '0;
            end
            if (do_clear) begin
               for (int i = 0; i < NumFlows; i++) begin
                  head_ff[i]  <= '0;
                  count_ff[i] <= '0;
               end
            end
         end
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = rs_ff;
   assign rsp_out_handle = deq_ok_ff ? 16'(ram_rd) : 16'd0;
   assign rsp_out_flow   = rf_ff;
   assign rsp_all_empty  = re_ff;
endmodule
`default_nettype wire

// ----- design/round_robin_flow_queue_unit.sv -----
// Top level: round robin per-flow queue scheduler.
// Flow: a request is captured into the request registers, executed in the
// execute state, and its response is held in the response registers.
// A new request is taken only in idle; busy is high in the execute cycle,
// in which the link table and the task store read are used.
// Reset (synchronous): all flows inactive, counts/heads zero, pointer zero.
// The receiver cannot stall; each response shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_flow_queue_unit import rrfq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [3:0]  req_flow_id,
   input  wire logic [15:0] req_task_handle,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_out_handle,
   output logic [3:0]       rsp_out_flow,
   output logic             rsp_all_empty
);
   dp_cmd_type cmd;

   // sequencer: capture request, then execute read-modify-write
   rrfq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .cmd(cmd)
   );

   // links, FIFO state, task store, response registers
   rrfq_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_action(req_action), .req_flow_id(req_flow_id),
      .req_task_handle(req_task_handle),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_out_handle(rsp_out_handle), .rsp_out_flow(rsp_out_flow),
      .rsp_all_empty(rsp_all_empty)
   );
endmodule
`default_nettype wire

// ----- design/rrfq_checker.sv -----
// Port-level checker for the round robin flow queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rrfq_checker import rrfq_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_out_handle,
   input wire logic [3:0]  rsp_out_flow
);
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid) else $error("missing response");
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");
   a_no_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response repeated");
   a_flow_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_out_flow == 4'd0 && rsp_out_handle == 16'd0))
      else $error("nonzero payload on failure");
endmodule

bind round_robin_flow_queue_unit rrfq_checker u_rrfq_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_out_handle(rsp_out_handle), .rsp_out_flow(rsp_out_flow)
);
`default_nettype wire
